[rtl/lpld_pkg.sv]
`default_nettype none

package lpld_pkg;

  // Number format
  localparam int unsigned LengthDigits = 6;
  localparam int unsigned NumW         = 20;
  localparam int unsigned CntW         = $clog2(LengthDigits + 1);
  localparam logic [NumW-1:0] NumMax   = {NumW{1'b1}};

  // Framing characters
  localparam logic [7:0] ChOpen  = 8'h5B;  // '['
  localparam logic [7:0] ChSep   = 8'h3A;  // ':'
  localparam logic [7:0] ChClose = 8'h5D;  // ']'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  // Parser phases, one-hot
  typedef enum logic [9:0] {
    PH_OPEN      = 10'b00_0000_0001,
    PH_COUNT     = 10'b00_0000_0010,
    PH_COUNT_SEP = 10'b00_0000_0100,
    PH_LEN       = 10'b00_0000_1000,
    PH_LEN_SEP   = 10'b00_0001_0000,
    PH_DATA      = 10'b00_0010_0000,
    PH_ELEM_SEP  = 10'b00_0100_0000,
    PH_CLOSE     = 10'b00_1000_0000,
    PH_DONE      = 10'b01_0000_0000,
    PH_HALT      = 10'b10_0000_0000
  } phase_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_OPEN  = 3'd0,
    ERR_DIGIT = 3'd1,
    ERR_SEP   = 3'd2,
    ERR_CLOSE = 3'd3,
    ERR_TRUNC = 3'd4
  } err_e;

  // One result word
  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data_byte;
    logic            elem_end;
    logic [NumW-1:0] number;
    err_e            code;
  } res_t;

  // Whitespace skipped before separators and brackets
  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  endfunction

endpackage

`default_nettype wire

[rtl/lpld_parser.sv]
`default_nettype none

module lpld_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          in_first_i,
  input  wire logic          in_last_i,
  input  wire logic          res_ready_i,
  output logic               res_valid_o,
  output lpld_pkg::res_t     res_o
);

  // Input register
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       in_last_q;

  // Parser state
  lpld_pkg::phase_e              phase_q, phase_d;
  logic [lpld_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [lpld_pkg::NumW-1:0]     acc_q, acc_d;
  logic [lpld_pkg::NumW-1:0]     elems_q, elems_d;
  logic [lpld_pkg::NumW-1:0]     bytes_q, bytes_d;
  logic [lpld_pkg::NumW-1:0]     index_q, index_d;

  // Working values
  lpld_pkg::phase_e              ph_cur;
  logic [lpld_pkg::CntW-1:0]     cnt_cur, cnt_inc;
  logic [lpld_pkg::NumW-1:0]     acc_cur, elems_cur, bytes_cur, index_cur;
  logic [lpld_pkg::NumW-1:0]     acc_sat, elems_dec, bytes_dec;
  logic [lpld_pkg::NumW+3:0]     acc_wide;
  logic                          is_digit, blank, num_done, stop;
  logic                          advance;
  lpld_pkg::res_t                res;
  logic                          res_v;

  assign advance    = in_v_q && res_ready_i;
  assign in_ready_o = !in_v_q || res_ready_i;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q  <= in_byte_i;
      in_first_q <= in_first_i;
      in_last_q  <= in_last_i;
    end
  end

  // A message start restarts from the reset state
  always_comb begin
    ph_cur    = in_first_q ? lpld_pkg::PH_OPEN : phase_q;
    cnt_cur   = in_first_q ? '0 : cnt_q;
    acc_cur   = in_first_q ? '0 : acc_q;
    elems_cur = in_first_q ? '0 : elems_q;
    bytes_cur = in_first_q ? '0 : bytes_q;
    index_cur = in_first_q ? '0 : index_q;
  end

  // Digit accumulate: acc*10 + digit, saturating
  assign is_digit  = (in_byte_q >= lpld_pkg::ChZero) && (in_byte_q <= lpld_pkg::ChNine);
  assign blank     = lpld_pkg::is_blank(in_byte_q);
  assign acc_wide  = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0}
                   + {{lpld_pkg::NumW{1'b0}}, in_byte_q[3:0]};
  assign acc_sat   = (|acc_wide[lpld_pkg::NumW+3:lpld_pkg::NumW]) ? lpld_pkg::NumMax
                                                                 : acc_wide[lpld_pkg::NumW-1:0];
  assign cnt_inc   = cnt_cur + 1'b1;
  assign num_done  = cnt_inc >= lpld_pkg::CntW'(lpld_pkg::LengthDigits);
  assign elems_dec = elems_cur - 1'b1;
  assign bytes_dec = bytes_cur - 1'b1;

  // Next state and result
  always_comb begin
    phase_d = ph_cur;
    cnt_d   = cnt_cur;
    acc_d   = acc_cur;
    elems_d = elems_cur;
    bytes_d = bytes_cur;
    index_d = index_cur;
    res     = '0;
    res_v   = 1'b0;
    stop    = 1'b0;

    unique case (ph_cur)
      lpld_pkg::PH_OPEN: begin
        if (in_byte_q == lpld_pkg::ChOpen) begin
          phase_d = lpld_pkg::PH_COUNT;
          cnt_d   = '0;
          acc_d   = '0;
        end else if (!blank) begin
          stop = 1'b1; res_v = 1'b1;
          res.kind = lpld_pkg::KIND_ERROR; res.code = lpld_pkg::ERR_OPEN;
        end
      end
      lpld_pkg::PH_COUNT, lpld_pkg::PH_LEN: begin
        if (!is_digit) begin
          stop = 1'b1; res_v = 1'b1;
          res.kind = lpld_pkg::KIND_ERROR; res.code = lpld_pkg::ERR_DIGIT;
        end else begin
          acc_d = acc_sat;
          cnt_d = cnt_inc;
          if (num_done) begin
            if (ph_cur == lpld_pkg::PH_COUNT) begin
              elems_d = acc_sat;
              phase_d = lpld_pkg::PH_COUNT_SEP;
            end else begin
              bytes_d = acc_sat;
              phase_d = lpld_pkg::PH_LEN_SEP;
            end
          end
        end
      end
      lpld_pkg::PH_COUNT_SEP: begin
        if (in_byte_q == lpld_pkg::ChSep) begin
          index_d = '0;
          cnt_d   = '0;
          acc_d   = '0;
          phase_d = (elems_cur == '0) ? lpld_pkg::PH_CLOSE : lpld_pkg::PH_LEN;
        end else if (!blank) begin
          stop = 1'b1; res_v = 1'b1;
          res.kind = lpld_pkg::KIND_ERROR; res.code = lpld_pkg::ERR_SEP;
        end
      end
      lpld_pkg::PH_LEN_SEP: begin
        if (in_byte_q == lpld_pkg::ChSep) begin
          if (bytes_cur == '0) begin
            res_v = 1'b1;
            res.kind   = lpld_pkg::KIND_EMPTY;
            res.number = index_cur;
            phase_d    = lpld_pkg::PH_ELEM_SEP;
          end else begin
            phase_d = lpld_pkg::PH_DATA;
          end
        end else if (!blank) begin
          stop = 1'b1; res_v = 1'b1;
          res.kind = lpld_pkg::KIND_ERROR; res.code = lpld_pkg::ERR_SEP;
        end
      end
      lpld_pkg::PH_DATA: begin
        res_v = 1'b1;
        res.kind      = lpld_pkg::KIND_BYTE;
        res.data_byte = in_byte_q;
        res.elem_end  = (bytes_cur == lpld_pkg::NumW'(1));
        res.number    = index_cur;
        bytes_d       = bytes_dec;
        if (bytes_dec == '0) begin
          phase_d = lpld_pkg::PH_ELEM_SEP;
        end
      end
      lpld_pkg::PH_ELEM_SEP: begin
        if (in_byte_q == lpld_pkg::ChSep) begin
          index_d = index_cur + 1'b1;
          elems_d = elems_dec;
          cnt_d   = '0;
          acc_d   = '0;
          phase_d = (elems_dec == '0) ? lpld_pkg::PH_CLOSE : lpld_pkg::PH_LEN;
        end else if (!blank) begin
          stop = 1'b1; res_v = 1'b1;
          res.kind = lpld_pkg::KIND_ERROR; res.code = lpld_pkg::ERR_SEP;
        end
      end
      lpld_pkg::PH_CLOSE: begin
        if (in_byte_q == lpld_pkg::ChClose) begin
          stop = 1'b1; res_v = 1'b1;
          res.kind   = lpld_pkg::KIND_DONE;
          res.number = index_cur;
          phase_d    = lpld_pkg::PH_DONE;
        end else if (!blank) begin
          stop = 1'b1; res_v = 1'b1;
          res.kind = lpld_pkg::KIND_ERROR; res.code = lpld_pkg::ERR_CLOSE;
        end
      end
      // done or halted: ignore until the next message start
      default: begin
        stop = 1'b1;
      end
    endcase

    if (stop && res.kind == lpld_pkg::KIND_ERROR && res_v) begin
      phase_d = lpld_pkg::PH_HALT;
    end

    // Message ended before the parse finished
    if (in_last_q && !stop) begin
      phase_d  = lpld_pkg::PH_HALT;
      res_v    = 1'b1;
      res      = '0;
      res.kind = lpld_pkg::KIND_ERROR;
      res.code = lpld_pkg::ERR_TRUNC;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lpld_pkg::PH_OPEN;
      cnt_q   <= '0;
      acc_q   <= '0;
      elems_q <= '0;
      bytes_q <= '0;
      index_q <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      elems_q <= elems_d;
      bytes_q <= bytes_d;
      index_q <= index_d;
    end
  end

  assign res_valid_o = advance && res_v;
  assign res_o       = res;

endmodule

`default_nettype wire

[rtl/lpld_skid.sv]
`default_nettype none

module lpld_skid (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lpld_pkg::res_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lpld_pkg::res_t      out_data_o
);

  logic           out_v_q, skid_v_q;
  lpld_pkg::res_t out_q, skid_q;
  logic           in_fire, load;

  // Ready comes from a register only
  assign in_ready_o = !skid_v_q;
  assign in_fire    = in_valid_i && !skid_v_q;
  assign load       = !out_v_q || out_ready_i;

  // Output register plus one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load) begin
      out_v_q  <= skid_v_q || in_fire;
      skid_v_q <= 1'b0;
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= skid_v_q ? skid_q : in_data_i;
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/length_prefixed_list_deframer_unit.sv]
// Length-prefixed list deframer. Takes one message byte per word on the
// slave stream ('[', six-digit count, ':', per element a six-digit length,
// ':', the payload and ':', then ']') and emits zero or one result word per
// byte: a payload byte with its element index, an empty-element marker, a
// completion with the element count, or an error code. A byte flagged in
// tuser restarts the parser; a byte flagged in tlast that leaves the parse
// unfinished gives a truncation error. Throughput is one byte per clock while
// the master side does not stall. Each byte passes the input register ahead of
// the parser, and its result the result register behind it. A result skid entry
// keeps the slave side running after the master side stalls, until it fills.
`default_nettype none

module length_prefixed_list_deframer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  wire logic        s_axis_tuser,   // [0] msg_first
  input  wire logic        s_axis_tlast,   // msg_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] element_byte, [27:8] element_number,
                                           // [30:28] error_code, [31] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
  output logic             m_axis_tlast    // element_end
);

  lpld_pkg::res_t res, out_res;
  logic           res_valid, res_ready;

  // Parse stage
  lpld_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_first_i  (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  lpld_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.code, out_res.number, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.elem_end;

endmodule

`default_nettype wire

[rtl/lpld_checker.sv]
`default_nettype none

module lpld_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // Stalled result word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // End-of-element only on payload bytes
  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == lpld_pkg::KIND_BYTE)
    else $error("tlast on a non-payload word");

  // Error words carry a valid code and nothing else
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == lpld_pkg::KIND_ERROR |->
      m_axis_tdata[27:0] == 28'd0 && m_axis_tdata[30:28] <= lpld_pkg::ERR_TRUNC)
    else $error("malformed error word");

  // Non-error words carry no code
  a_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != lpld_pkg::KIND_ERROR |->
      m_axis_tdata[31:28] == 4'd0)
    else $error("code set on a non-error word");

endmodule

bind length_prefixed_list_deframer_unit lpld_checker u_lpld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
